FILE: rtl/ucu_pkg.sv
package ucu_pkg;

    typedef logic signed [31:0] q_t;

    localparam q_t Q_MAX = 32'sh7fffffff;
    localparam q_t Q_MIN = 32'sh80000000;

    localparam int CFG_IDX_W       = 3;
    localparam int KIND_W          = 3;
    localparam int FRONT_STAGES    = 6;
    localparam int DIV_STEPS       = 4;
    localparam int DIV_NUM_W       = 48;
    localparam int DIV_STAGES      = DIV_NUM_W / DIV_STEPS;
    localparam int PIPE_STAGES     = FRONT_STAGES + DIV_STAGES + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CELL_VOLUME    = 3'd0,
        REG_INV_TIME_STEP  = 3'd1,
        REG_VISCOSITY      = 3'd2,
        REG_INV_DX_SQUARED = 3'd3,
        REG_INV_DY_SQUARED = 3'd4
    } cfg_reg_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_UNUSED       = 3'd0,
        KIND_CALCULATED   = 3'd1,
        KIND_DONOR        = 3'd2,
        KIND_DONOR_BUFFER = 3'd3,
        KIND_RECEIVER     = 3'd4
    } point_kind_t;

    typedef struct packed {
        logic [31:0] cell_volume;
        logic [31:0] inv_time_step;
        logic [31:0] viscosity;
        logic [31:0] inv_dx_squared;
        logic [31:0] inv_dy_squared;
    } cfg_t;

    typedef struct packed {
        q_t   c;
        q_t   ue;
        q_t   uw;
        q_t   un;
        q_t   us;
        q_t   fe;
        q_t   fw;
        q_t   fn;
        q_t   fs;
        q_t   outflow;
        q_t   dxx;
        q_t   dyy;
        q_t   cmo;
        q_t   ddsum;
        logic active;
    } f1_t;

    typedef struct packed {
        q_t   c;
        q_t   pe;
        q_t   pw;
        q_t   pn;
        q_t   ps;
        q_t   apc;
        q_t   pdx;
        q_t   pdy;
        q_t   dd;
        q_t   t0;
        q_t   cmo;
        logic active;
    } f2_t;

    typedef struct packed {
        q_t   c;
        q_t   fc;
        q_t   fdsum;
        q_t   ndd;
        q_t   tc;
        q_t   apa;
        logic active;
    } f3_t;

    typedef struct packed {
        q_t   c;
        q_t   fc;
        q_t   tc;
        q_t   fd;
        q_t   ap;
        logic active;
    } f4_t;

    typedef struct packed {
        q_t   c;
        q_t   ap;
        q_t   nfd;
        q_t   r1;
        logic active;
    } f5_t;

    typedef struct packed {
        q_t   c;
        q_t   res;
        q_t   ap;
        logic active;
    } f6_t;

    typedef struct packed {
        q_t                   c;
        q_t                   res;
        logic                 neg;
        logic                 fault;
        logic                 active;
        logic [DIV_NUM_W-1:0] num;
        logic [31:0]          rem;
        logic [31:0]          ma;
    } div_t;

    function automatic q_t q_sat(input logic signed [34:0] v);
        if (v > 35'(Q_MAX)) return Q_MAX;
        if (v < 35'(Q_MIN)) return Q_MIN;
        return v[31:0];
    endfunction

    function automatic q_t q_add(input q_t a, input q_t b);
        return q_sat(35'(a) + 35'(b));
    endfunction

    function automatic q_t q_sub(input q_t a, input q_t b);
        return q_sat(35'(a) - 35'(b));
    endfunction

    function automatic logic signed [32:0] ux(input logic [31:0] v);
        return $signed({1'b0, v});
    endfunction

    // rounded to nearest on the magnitude, ties away from zero
    function automatic q_t q_mul(input logic signed [32:0] a, input logic signed [32:0] b);
        logic signed [65:0] p;
        logic [65:0]        m;
        logic [49:0]        r;
        p = a * b;
        m = p[65] ? 66'(-p) : 66'(p);
        r = 50'((m + 66'h8000) >> 16);
        if (p[65]) begin
            if (r > 50'd2147483648) return Q_MIN;
            return q_t'(32'(-r[31:0]));
        end
        if (r > 50'd2147483647) return Q_MAX;
        return q_t'(r[31:0]);
    endfunction

endpackage

FILE: rtl/ucu_front.sv
module ucu_front (
    input  logic                                  clk,
    input  logic [ucu_pkg::FRONT_STAGES-1:0]      en,
    input  ucu_pkg::cfg_t                         cfg,
    input  ucu_pkg::q_t                           center_value,
    input  ucu_pkg::q_t                           east_value,
    input  ucu_pkg::q_t                           west_value,
    input  ucu_pkg::q_t                           north_value,
    input  ucu_pkg::q_t                           south_value,
    input  ucu_pkg::q_t                           old_value,
    input  ucu_pkg::q_t                           east_flux,
    input  ucu_pkg::q_t                           west_flux,
    input  ucu_pkg::q_t                           north_flux,
    input  ucu_pkg::q_t                           south_flux,
    input  logic [ucu_pkg::KIND_W-1:0]            point_kind,
    output ucu_pkg::f6_t                          s6
);
    import ucu_pkg::*;

    f1_t s1_reg, s1_next;
    f2_t s2_reg, s2_next;
    f3_t s3_reg, s3_next;
    f4_t s4_reg, s4_next;
    f5_t s5_reg, s5_next;
    f6_t s6_reg, s6_next;

    always_comb
    begin
        q_t o;
        q_t twoc;
        s1_next.c  = center_value;
        s1_next.fe = east_flux;
        s1_next.fw = west_flux;
        s1_next.fn = north_flux;
        s1_next.fs = south_flux;
        s1_next.ue = east_flux[31]  ? east_value  : center_value;
        s1_next.uw = west_flux[31]  ? west_value  : center_value;
        s1_next.un = north_flux[31] ? north_value : center_value;
        s1_next.us = south_flux[31] ? south_value : center_value;
        o = '0;
        if (!east_flux[31])  o = q_add(o, east_flux);
        if (!west_flux[31])  o = q_add(o, west_flux);
        if (!north_flux[31]) o = q_add(o, north_flux);
        if (!south_flux[31]) o = q_add(o, south_flux);
        s1_next.outflow = o;
        twoc = q_add(center_value, center_value);
        s1_next.dxx = q_sub(q_add(east_value, west_value), twoc);
        s1_next.dyy = q_sub(q_add(north_value, south_value), twoc);
        s1_next.cmo = q_sub(center_value, old_value);
        s1_next.ddsum = q_add(q_sat($signed({2'b00, cfg.inv_dx_squared, 1'b0})),
                              q_sat($signed({2'b00, cfg.inv_dy_squared, 1'b0})));
        s1_next.active = (point_kind == KIND_CALCULATED) || (point_kind == KIND_DONOR)
                      || (point_kind == KIND_DONOR_BUFFER);
    end

    always_comb
    begin
        s2_next.c      = s1_reg.c;
        s2_next.cmo    = s1_reg.cmo;
        s2_next.active = s1_reg.active;
        s2_next.pe     = q_mul(33'(s1_reg.ue), 33'(s1_reg.fe));
        s2_next.pw     = q_mul(33'(s1_reg.uw), 33'(s1_reg.fw));
        s2_next.pn     = q_mul(33'(s1_reg.un), 33'(s1_reg.fn));
        s2_next.ps     = q_mul(33'(s1_reg.us), 33'(s1_reg.fs));
        s2_next.apc    = q_mul(33'(s1_reg.outflow), ux(cfg.cell_volume));
        s2_next.pdx    = q_mul(33'(s1_reg.dxx), ux(cfg.inv_dx_squared));
        s2_next.pdy    = q_mul(33'(s1_reg.dyy), ux(cfg.inv_dy_squared));
        s2_next.dd     = q_mul(ux(cfg.cell_volume), 33'(s1_reg.ddsum));
        s2_next.t0     = q_mul(ux(cfg.cell_volume), ux(cfg.inv_time_step));
    end

    always_comb
    begin
        s3_next.c      = s2_reg.c;
        s3_next.active = s2_reg.active;
        s3_next.fc     = q_add(q_add(q_add(s2_reg.pe, s2_reg.pw), s2_reg.pn), s2_reg.ps);
        s3_next.fdsum  = q_add(s2_reg.pdx, s2_reg.pdy);
        s3_next.ndd    = q_mul(ux(cfg.viscosity), 33'(s2_reg.dd));
        s3_next.tc     = q_mul(33'(s2_reg.t0), 33'(s2_reg.cmo));
        s3_next.apa    = q_add(s2_reg.t0, s2_reg.apc);
    end

    always_comb
    begin
        s4_next.c      = s3_reg.c;
        s4_next.active = s3_reg.active;
        s4_next.fc     = s3_reg.fc;
        s4_next.tc     = s3_reg.tc;
        s4_next.fd     = q_mul(ux(cfg.cell_volume), 33'(s3_reg.fdsum));
        s4_next.ap     = q_add(s3_reg.apa, s3_reg.ndd);
    end

    always_comb
    begin
        s5_next.c      = s4_reg.c;
        s5_next.active = s4_reg.active;
        s5_next.ap     = s4_reg.ap;
        s5_next.nfd    = q_mul(ux(cfg.viscosity), 33'(s4_reg.fd));
        s5_next.r1     = q_add(s4_reg.tc, s4_reg.fc);
    end

    always_comb
    begin
        s6_next.c      = s5_reg.c;
        s6_next.active = s5_reg.active;
        s6_next.ap     = s5_reg.ap;
        s6_next.res    = s5_reg.active ? q_sub('0, q_sub(s5_reg.r1, s5_reg.nfd)) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) s1_reg <= s1_next;
        if (en[1]) s2_reg <= s2_next;
        if (en[2]) s3_reg <= s3_next;
        if (en[3]) s4_reg <= s4_next;
        if (en[4]) s5_reg <= s5_next;
        if (en[5]) s6_reg <= s6_next;
    end

    assign s6 = s6_reg;

endmodule

FILE: rtl/ucu_div_stage.sv
module ucu_div_stage (
    input  logic          clk,
    input  logic          en,
    input  ucu_pkg::div_t d_in,
    output ucu_pkg::div_t d_out
);
    import ucu_pkg::*;

    div_t d_reg, d_next;

    // restoring division, one quotient bit per step
    always_comb
    begin
        logic [32:0] rs;
        d_next = d_in;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            rs = {d_next.rem, d_next.num[DIV_NUM_W-1]};
            d_next.num = {d_next.num[DIV_NUM_W-2:0], 1'b0};
            if (rs >= {1'b0, d_next.ma})
            begin
                rs = rs - {1'b0, d_next.ma};
                d_next.num[0] = 1'b1;
            end
            d_next.rem = rs[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) d_reg <= d_next;
    end

    assign d_out = d_reg;

endmodule

FILE: rtl/upwind_momentum_cell_update.sv
// Channel   Signals                                  Direction
// request   in_valid, in_stall, centre..point_kind   in (in_stall out)
// result    out_valid, out_stall, new_value..fault   out (out_stall in)
// config    write_enable, write_index, write_data     in
//
// 19 register stages: 6 arithmetic, 12 divider (4 quotient bits each), 1 final.
// One request per cycle while in_stall is low.
// rst_n clears valid bits and loads register defaults; payload is not reset.
// Per-stage ready lets bubbles collapse while out_stall holds the result.
module upwind_momentum_cell_update (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              write_enable,
    input  logic [ucu_pkg::CFG_IDX_W-1:0]     write_index,
    input  logic [31:0]                       write_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [31:0]                center_value,
    input  logic signed [31:0]                east_value,
    input  logic signed [31:0]                west_value,
    input  logic signed [31:0]                north_value,
    input  logic signed [31:0]                south_value,
    input  logic signed [31:0]                old_value,
    input  logic signed [31:0]                east_flux,
    input  logic signed [31:0]                west_flux,
    input  logic signed [31:0]                north_flux,
    input  logic signed [31:0]                south_flux,
    input  logic [ucu_pkg::KIND_W-1:0]        point_kind,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [31:0]                new_value,
    output logic signed [31:0]                residual,
    output logic                              divide_fault
);
    import ucu_pkg::*;

    cfg_t cfg_reg;
    logic [PIPE_STAGES-1:0] v_reg, v_next, ready;
    f6_t  s6;
    div_t div_chain [DIV_STAGES+1];

    typedef struct packed {
        q_t   new_value;
        q_t   residual;
        logic fault;
    } out_t;
    out_t out_reg, out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_volume    <= 32'd65536;
            cfg_reg.inv_time_step  <= 32'd65536;
            cfg_reg.viscosity      <= 32'd655;
            cfg_reg.inv_dx_squared <= 32'd65536;
            cfg_reg.inv_dy_squared <= 32'd65536;
        end
        else if (write_enable)
        begin
            unique case (cfg_reg_t'(write_index))
                REG_CELL_VOLUME:    cfg_reg.cell_volume    <= write_data;
                REG_INV_TIME_STEP:  cfg_reg.inv_time_step  <= write_data;
                REG_VISCOSITY:      cfg_reg.viscosity      <= write_data;
                REG_INV_DX_SQUARED: cfg_reg.inv_dx_squared <= write_data;
                REG_INV_DY_SQUARED: cfg_reg.inv_dy_squared <= write_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        ready[PIPE_STAGES-1] = !v_reg[PIPE_STAGES-1] || !out_stall;
        for (int i = PIPE_STAGES - 2; i >= 0; i--)
            ready[i] = !v_reg[i] || ready[i+1];
        for (int i = 0; i < PIPE_STAGES; i++)
        begin
            if (!ready[i])  v_next[i] = v_reg[i];
            else if (i == 0) v_next[i] = in_valid;
            else            v_next[i] = v_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v_reg <= '0;
        else        v_reg <= v_next;
    end

    assign in_stall  = !ready[0];
    assign out_valid = v_reg[PIPE_STAGES-1];

    ucu_front u_front (
        .clk          (clk),
        .en           (ready[FRONT_STAGES-1:0]),
        .cfg          (cfg_reg),
        .center_value (center_value),
        .east_value   (east_value),
        .west_value   (west_value),
        .north_value  (north_value),
        .south_value  (south_value),
        .old_value    (old_value),
        .east_flux    (east_flux),
        .west_flux    (west_flux),
        .north_flux   (north_flux),
        .south_flux   (south_flux),
        .point_kind   (point_kind),
        .s6           (s6)
    );

    // divider set-up: magnitudes, sign and half-divisor rounding term
    always_comb
    begin
        logic [31:0] mr;
        logic [31:0] ma;
        mr = s6.res[31] ? 32'(-s6.res) : 32'(s6.res);
        ma = s6.ap[31]  ? 32'(-s6.ap)  : 32'(s6.ap);
        div_chain[0].c      = s6.c;
        div_chain[0].res    = s6.res;
        div_chain[0].active = s6.active;
        div_chain[0].neg    = s6.res[31] ^ s6.ap[31];
        div_chain[0].fault  = s6.active && (s6.ap == '0);
        div_chain[0].ma     = ma;
        div_chain[0].rem    = '0;
        div_chain[0].num    = {mr, 16'h0000} + DIV_NUM_W'(ma[31:1]);
    end

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        ucu_div_stage u_div (
            .clk   (clk),
            .en    (ready[FRONT_STAGES+g]),
            .d_in  (div_chain[g]),
            .d_out (div_chain[g+1])
        );
    end

    always_comb
    begin
        div_t        d;
        q_t          qs;
        d = div_chain[DIV_STAGES];
        if (d.neg)
            qs = (d.num > DIV_NUM_W'(48'd2147483648)) ? Q_MIN : q_t'(32'(-d.num[31:0]));
        else
            qs = (d.num > DIV_NUM_W'(48'd2147483647)) ? Q_MAX : q_t'(d.num[31:0]);
        out_next.new_value = (d.active && !d.fault) ? q_add(d.c, qs) : d.c;
        out_next.residual  = d.res;
        out_next.fault     = d.fault;
    end

    always_ff @(posedge clk)
    begin
        if (ready[PIPE_STAGES-1]) out_reg <= out_next;
    end

    assign new_value    = out_reg.new_value;
    assign residual     = out_reg.residual;
    assign divide_fault = out_reg.fault;

    a_empty_out_never_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[PIPE_STAGES-1] |-> !in_stall)
        else $error("input stalled with an empty output stage");

    a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v_reg[0])
        else $error("accepted request not captured");

    a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (int'($countones(v_reg)) == int'($past($countones(v_reg)))
                 + int'($past(in_valid && !in_stall)) - int'($past(out_valid && !out_stall))))
        else $error("request lost or duplicated in pipeline");

endmodule

FILE: sim/tb_upwind_momentum_cell_update.sv
`timescale 1ns / 100ps

module tb_upwind_momentum_cell_update;
    import ucu_pkg::*;

    typedef struct {
        logic signed [31:0] c, e, w, n, s, o, fe, fw, fn, fs;
        logic [2:0]         kind;
    } cell_req_t;

    typedef struct {
        logic signed [31:0] nv;
        logic signed [31:0] res;
        logic               fault;
    } cell_res_t;

    logic                clk;
    logic                rst_n;
    logic                write_enable;
    logic [CFG_IDX_W-1:0] write_index;
    logic [31:0]         write_data;
    logic                in_valid;
    logic                in_stall;
    logic signed [31:0]  center_value, east_value, west_value, north_value, south_value;
    logic signed [31:0]  old_value, east_flux, west_flux, north_flux, south_flux;
    logic [KIND_W-1:0]   point_kind;
    logic                out_valid;
    logic                out_stall;
    logic signed [31:0]  new_value;
    logic signed [31:0]  residual;
    logic                divide_fault;

    logic [31:0] vol_q, idt_q, nu_q, idx2_q, idy2_q;
    cell_res_t   expected_updates[$];
    int          mismatches;
    int          received;
    bit          hold_off;
    bit          fill_mode;

    upwind_momentum_cell_update DUT (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint sat(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        bit     neg;
        longint ma, mb;
        longint unsigned p;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = (longint'(ma) * longint'(mb) + 64'h8000) >> 16;
        if (neg) return (p > 64'd2147483648) ? -64'sd2147483648 : -longint'(p);
        return (p > 64'd2147483647) ? 64'sd2147483647 : longint'(p);
    endfunction

    function automatic cell_res_t predict_update(cell_req_t q);
        cell_res_t r;
        longint c, e, w, n, s, o, fe, fw, fn, fs;
        longint vol, idt, nu, ix, iy;
        longint outflow, fc, apc, twoc, dxx, dyy, fd, dd, t0, rr, ap, res, qs;
        longint unsigned mr, ma, qt;
        bit neg;
        c = q.c; e = q.e; w = q.w; n = q.n; s = q.s; o = q.o;
        fe = q.fe; fw = q.fw; fn = q.fn; fs = q.fs;
        vol = vol_q; idt = idt_q; nu = nu_q; ix = idx2_q; iy = idy2_q;
        r.nv = q.c;
        r.res = 0;
        r.fault = 1'b0;
        if (q.kind >= KIND_CALCULATED && q.kind <= KIND_DONOR_BUFFER) begin
            outflow = 0;
            if (fe >= 0) outflow = sat(outflow + fe);
            if (fw >= 0) outflow = sat(outflow + fw);
            if (fn >= 0) outflow = sat(outflow + fn);
            if (fs >= 0) outflow = sat(outflow + fs);
            fc = fx_mul((fe >= 0) ? c : e, fe);
            fc = sat(fc + fx_mul((fw >= 0) ? c : w, fw));
            fc = sat(fc + fx_mul((fn >= 0) ? c : n, fn));
            fc = sat(fc + fx_mul((fs >= 0) ? c : s, fs));
            apc = fx_mul(outflow, vol);
            twoc = sat(c + c);
            dxx = sat(sat(e + w) - twoc);
            dyy = sat(sat(n + s) - twoc);
            fd = fx_mul(vol, sat(fx_mul(dxx, ix) + fx_mul(dyy, iy)));
            dd = fx_mul(vol, sat(sat(ix + ix) + sat(iy + iy)));
            t0 = fx_mul(vol, idt);
            rr = sat(fx_mul(t0, sat(c - o)) + fc);
            rr = sat(rr - fx_mul(nu, fd));
            res = sat(-rr);
            ap = sat(sat(t0 + apc) + fx_mul(nu, dd));
            r.res = res[31:0];
            if (ap == 0) begin
                r.fault = 1'b1;
            end
            else begin
                neg = (res < 0) != (ap < 0);
                mr = (res < 0) ? -res : res;
                ma = (ap < 0) ? -ap : ap;
                qt = ((mr << 16) + (ma >> 1)) / ma;
                if (neg) qs = (qt > 64'd2147483648) ? -64'sd2147483648 : -longint'(qt);
                else qs = (qt > 64'd2147483647) ? 64'sd2147483647 : longint'(qt);
                r.nv = sat(c + qs);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    // result side: after each result, wait a drawn number of cycles before the next
    initial begin
        int gap;
        cell_res_t x;
        gap = 0;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                received++;
                if (expected_updates.size() == 0) begin
                    report_mismatch("unexpected result", new_value, 32'h0);
                end
                else begin
                    x = expected_updates.pop_front();
                    if (new_value !== x.nv) report_mismatch("new_value", new_value, x.nv);
                    if (residual !== x.res) report_mismatch("residual", residual, x.res);
                    if (divide_fault !== x.fault)
                        report_mismatch("divide_fault", divide_fault, 32'(x.fault));
                end
                if (fill_mode || $urandom_range(0, 1) != 0) gap = 0;
                else gap = $urandom_range(0, 11);
            end
            @(negedge clk);
            if (hold_off) out_stall <= 1'b1;
            else if (gap > 0) begin
                out_stall <= 1'b1;
                gap--;
            end
            else out_stall <= 1'b0;
        end
    end

    task automatic send_cell(cell_req_t q, bit no_gap = 0);
        int gap;
        gap = (no_gap || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        center_value <= q.c; east_value <= q.e; west_value <= q.w;
        north_value <= q.n; south_value <= q.s; old_value <= q.o;
        east_flux <= q.fe; west_flux <= q.fw; north_flux <= q.fn; south_flux <= q.fs;
        point_kind <= q.kind;
        do @(posedge clk); while (in_stall);
        expected_updates.push_back(predict_update(q));
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_updates.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
        write_enable <= 1'b1;
        write_index <= idx;
        write_data <= v;
        @(negedge clk);
        write_enable <= 1'b0;
        case (idx)
            REG_CELL_VOLUME:    vol_q = v;
            REG_INV_TIME_STEP:  idt_q = v;
            REG_VISCOSITY:      nu_q = v;
            REG_INV_DX_SQUARED: idx2_q = v;
            REG_INV_DY_SQUARED: idy2_q = v;
            default: ;
        endcase
    endtask

    task automatic write_bad_index;
        write_enable <= 1'b1;
        write_index <= 3'd5 + 3'($urandom_range(0, 2));
        write_data <= $urandom;
        @(negedge clk);
        write_enable <= 1'b0;
    endtask

    function automatic logic [31:0] pick_q();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            4: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
            default: return $urandom;
        endcase
    endfunction

    function automatic cell_req_t rand_cell(bit active);
        cell_req_t q;
        q.c = pick_q(); q.e = pick_q(); q.w = pick_q(); q.n = pick_q();
        q.s = pick_q(); q.o = pick_q();
        q.fe = pick_q(); q.fw = pick_q(); q.fn = pick_q(); q.fs = pick_q();
        q.kind = active ? 3'($urandom_range(1, 3)) : 3'($urandom_range(0, 7));
        return q;
    endfunction

    task automatic test_directed;
        cell_req_t q;
        point_kind_t k;
        q = '{default: 0, kind: KIND_CALCULATED};
        send_cell(q);
        q = '{c: 32'h0001_0000, e: 32'h0002_0000, w: 32'hffff_0000, n: 32'h0000_8000,
              s: 32'h0003_0000, o: 32'h0000_4000, fe: 32'h0001_0000, fw: 32'hffff_8000,
              fn: 32'h0000_2000, fs: 32'hfffe_0000, kind: KIND_CALCULATED};
        for (int i = 0; i < 8; i++) begin
            q.kind = 3'(i);
            send_cell(q);
        end
        q = '{c: 32'h7fff_ffff, e: 32'h7fff_ffff, w: 32'h7fff_ffff, n: 32'h7fff_ffff,
              s: 32'h7fff_ffff, o: 32'h8000_0000, fe: 32'h7fff_ffff, fw: 32'h7fff_ffff,
              fn: 32'h7fff_ffff, fs: 32'h7fff_ffff, kind: KIND_DONOR};
        send_cell(q);
        q = '{c: 32'h8000_0000, e: 32'h8000_0000, w: 32'h8000_0000, n: 32'h8000_0000,
              s: 32'h8000_0000, o: 32'h7fff_ffff, fe: 32'h8000_0000, fw: 32'h8000_0000,
              fn: 32'h8000_0000, fs: 32'h8000_0000, kind: KIND_DONOR_BUFFER};
        send_cell(q);
        k = KIND_RECEIVER;
        q.kind = k;
        send_cell(q);
        drain();
        // zero diagonal
        write_reg(REG_CELL_VOLUME, 32'h0);
        write_bad_index();
        q = '{c: 32'h1234_5678, e: 32'h1, w: 32'h2, n: 32'h3, s: 32'h4, o: 32'h5,
              fe: 32'h1, fw: 32'hffff_ffff, fn: 32'h2, fs: 32'hffff_fff0,
              kind: KIND_CALCULATED};
        send_cell(q);
        drain();
        write_reg(REG_CELL_VOLUME, 32'h0001_0000);
    endtask

    task automatic test_random_phase(int count);
        for (int i = 0; i < count; i++)
            send_cell(rand_cell($urandom_range(0, 9) != 0));
        drain();
    endtask

    task automatic test_fill_stall;
        fill_mode = 1'b1;
        hold_off = 1'b1;
        fork
            begin
                repeat (60) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 40; i++) send_cell(rand_cell(1), 1);
        join
        drain();
        fill_mode = 1'b0;
    endtask

    task automatic set_all(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                           logic [31:0] d, logic [31:0] e);
        write_reg(REG_CELL_VOLUME, a);
        write_reg(REG_INV_TIME_STEP, b);
        write_reg(REG_VISCOSITY, c);
        write_reg(REG_INV_DX_SQUARED, d);
        write_reg(REG_INV_DY_SQUARED, e);
    endtask

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        rst_n = 1'b0;
        write_enable = 1'b0; write_index = '0; write_data = '0;
        in_valid = 1'b0;
        center_value = 0; east_value = 0; west_value = 0; north_value = 0;
        south_value = 0; old_value = 0; east_flux = 0; west_flux = 0;
        north_flux = 0; south_flux = 0; point_kind = '0;
        vol_q = 32'd65536; idt_q = 32'd65536; nu_q = 32'd655;
        idx2_q = 32'd65536; idy2_q = 32'd65536;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_phase(400);
        test_fill_stall();
        set_all(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        test_random_phase(250);
        set_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        test_random_phase(150);
        set_all(32'h0000_4000, 32'h000a_0000, 32'h0000_1000, 32'h0004_0000, 32'h0001_0000);
        test_random_phase(300);
        set_all($urandom, $urandom, $urandom, $urandom, $urandom);
        test_random_phase(250);
        set_all(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        test_random_phase(250);

        if (mismatches == 0 && expected_updates.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
